### rtl/wav_hdr_pkg.sv
// shared types, constants and header byte lookup for the wav header generator
package wav_hdr_pkg;

  localparam int HEADER_BYTES = 44;
  localparam int IDX_W        = $clog2(HEADER_BYTES);
  localparam int HDR_BITS     = HEADER_BYTES * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam logic [31:0] RST_SAMPLE_RATE   = 32'd16000;
  localparam logic [15:0] RST_SAMPLE_BITS   = 16'd16;
  localparam logic [15:0] RST_CHANNEL_COUNT = 16'd1;

  localparam logic [31:0] MAX_LEN = 32'hFFFF_FFDB;

  // four character tags, first character in the low byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] RIFF_EXTRA = 32'd36;
  localparam logic [31:0] FMT_SIZE   = 32'd16;
  localparam logic [15:0] FMT_PCM    = 16'd1;

  typedef struct packed {
    logic [31:0] len;
    logic        len_bad;
  } req_t;

  typedef struct packed {
    logic [31:0] len;
    logic        bad;
  } job_t;

  typedef struct packed {
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [15:0] channel_count;
    logic [15:0] align;
    logic [31:0] data_rate;
  } fmt_t;

  function automatic logic [7:0] hdr_byte(logic [IDX_W-1:0] idx, logic [31:0] len, fmt_t f);
    logic [HDR_BITS-1:0] hdr;
    logic [IDX_W+2:0]    pos;
    hdr = {len, TAG_DATA, f.sample_bits, f.align, f.data_rate, f.sample_rate,
           f.channel_count, FMT_PCM, FMT_SIZE, TAG_FMT, TAG_WAVE,
           len + RIFF_EXTRA, TAG_RIFF};
    pos = {idx, 3'b000};
    return hdr[pos +: 8];
  endfunction

endpackage

### rtl/wav_hdr_front.sv
// request queue: takes payload lengths and flags out-of-range lengths
module wav_hdr_front import wav_hdr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [31:0] payload_length,
  output logic        full,
  output logic        req_valid,
  output req_t        req,
  input  logic        req_pop
);

  req_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = count == 2'd2;
  assign req_valid = count != 2'd0;
  assign req       = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = req_pop && req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr].len     <= payload_length;
      mem[wr_ptr].len_bad <= (payload_length == 32'd0) || (payload_length > MAX_LEN);
    end
  end

endmodule

### rtl/wav_hdr_check.sv
// validation unit: bit-serial remainder of length by block align, then pass/fail
module wav_hdr_check import wav_hdr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  req_t req,
  output logic req_pop,
  input  fmt_t fmt,
  output logic job_valid,
  output job_t job,
  input  logic job_ready
);

  typedef enum logic [2:0] {
    CK_IDLE = 3'b001,
    CK_DIV  = 3'b010,
    CK_DONE = 3'b100
  } ck_state_t;

  ck_state_t   state;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [15:0] rem;
  logic        len_bad;
  logic [16:0] rem_sh;
  logic [15:0] rem_next;
  logic        cfg_bad;

  assign req_pop   = (state == CK_IDLE) && req_valid;
  assign job_valid = state == CK_DONE;

  assign rem_sh   = {rem, dvd[31]};
  assign rem_next = (rem_sh >= {1'b0, fmt.align}) ? 16'(rem_sh - {1'b0, fmt.align})
                                                  : rem_sh[15:0];
  assign cfg_bad  = (fmt.sample_rate == 32'd0) || (fmt.sample_bits == 16'd0) ||
                    (fmt.channel_count == 16'd0) || (fmt.sample_bits[2:0] != 3'd0) ||
                    (fmt.align == 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CK_IDLE;
    end else begin
      case (state)
        CK_IDLE: if (req_valid) state <= CK_DIV;
        CK_DIV:  if (cnt == 5'd31) state <= CK_DONE;
        CK_DONE: if (job_ready) state <= CK_IDLE;
        default: state <= CK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CK_IDLE: begin
        dvd     <= req.len;
        job.len <= req.len;
        len_bad <= req.len_bad;
        rem     <= 16'd0;
        cnt     <= 5'd0;
      end
      CK_DIV: begin
        dvd <= {dvd[30:0], 1'b0};
        rem <= rem_next;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) job.bad <= len_bad || cfg_bad || (rem_next != 16'd0);
      end
      default: ;
    endcase
  end

endmodule

### rtl/wav_hdr_emit.sv
// byte sequencer and output register for the 44-byte header or the error result
module wav_hdr_emit import wav_hdr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_ready,
  input  fmt_t       fmt,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] header_byte,
  output logic       error,
  output logic       last
);

  logic             active;
  logic [IDX_W-1:0] idx;
  job_t             cur;
  logic             out_valid;
  logic             adv;
  logic             finishing;

  assign empty     = !out_valid;
  assign adv       = !out_valid || pop;
  assign finishing = active && (cur.bad || idx == IDX_W'(HEADER_BYTES - 1));
  assign job_ready = adv && (!active || finishing);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= active;
        if (finishing) active <= 1'b0;
      end
      if (job_ready && job_valid) active <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && active) begin
      header_byte <= cur.bad ? 8'd0 : hdr_byte(idx, cur.len, fmt);
      error       <= cur.bad;
      last        <= finishing;
      idx         <= idx + IDX_W'(1);
    end
    if (job_ready && job_valid) begin
      cur <= job;
      idx <= '0;
    end
  end

endmodule

### rtl/wav_header_generator_core.sv
// top level of the wav header generator: config registers and the three stages
//
// Builds the 44-byte little-endian RIFF/WAVE PCM header for each payload length.
// Input channel: push/full carry payload_length; a transfer needs push high, full low.
// Result channel: empty/pop carry header_byte, error and last, one byte per transfer,
// in file order; last marks byte 43. A request failing validation gives one result
// with error and last high and header_byte zero.
// Config: cfg_write with cfg_index 0 sample_rate, 1 sample_bits, 2 channel_count;
// other indexes are ignored. Write only while no request is in flight.
// The first byte reaches the result ports through the request queue, a bit-serial remainder
// of the length by the block align in the validation unit, and the output register.
// Header requests are bounded by the single byte-wide output; a run of failing requests
// is bounded by the remainder unit. The remainder of the next request runs while the
// current header streams out.
// A two-entry request queue and one held check result decouple input from output,
// so push keeps being taken while pop is stalled until both are full.
// Reset clears all queues and the output and restores 16000 Hz, 16 bits, mono.
module wav_header_generator_core import wav_hdr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [31:0]           payload_length,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            header_byte,
  output logic                  error,
  output logic                  last,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [31:0] sample_rate;
  logic [15:0] sample_bits;
  logic [15:0] channel_count;
  logic [28:0] frame_bytes;
  logic [31:0] data_rate;
  fmt_t        fmt;
  logic        req_valid;
  req_t        req;
  logic        req_pop;
  logic        job_valid;
  job_t        job;
  logic        job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate   <= RST_SAMPLE_RATE;
      sample_bits   <= RST_SAMPLE_BITS;
      channel_count <= RST_CHANNEL_COUNT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SAMPLE_RATE:   sample_rate   <= cfg_data;
        CFG_SAMPLE_BITS:   sample_bits   <= cfg_data[15:0];
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // derived format fields: frame_bytes is registered from the config registers, data_rate from frame_bytes
  always_ff @(posedge clk) begin
    frame_bytes <= 29'(channel_count) * 29'(sample_bits[15:3]);
    data_rate   <= 32'(sample_rate * 32'(frame_bytes));
  end

  assign fmt.sample_rate   = sample_rate;
  assign fmt.sample_bits   = sample_bits;
  assign fmt.channel_count = channel_count;
  assign fmt.align         = frame_bytes[15:0];
  assign fmt.data_rate     = data_rate;

  wav_hdr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .payload_length (payload_length),
    .full           (full),
    .req_valid      (req_valid),
    .req            (req),
    .req_pop        (req_pop)
  );

  wav_hdr_check u_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .fmt       (fmt),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  wav_hdr_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (job),
    .job_ready   (job_ready),
    .fmt         (fmt),
    .empty       (empty),
    .pop         (pop),
    .header_byte (header_byte),
    .error       (error),
    .last        (last)
  );

endmodule

### rtl/wav_hdr_checker.sv
// port-level assertions for the wav header generator, bound to the top level
module wav_hdr_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] header_byte,
  input logic       error,
  input logic       last
);

  // reset leaves the result port empty and the request queue not full
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  // an error result is a single zero byte that closes the run
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && error) |-> (header_byte == 8'd0 && last))
    else $error("malformed error result");

  // inside a header run no error result may appear
  a_no_error_mid_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=> (empty || !error))
    else $error("error result inside a header run");

  // a result not taken stays on the ports
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(header_byte) && $stable(error) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind wav_header_generator_core wav_hdr_checker u_wav_hdr_checker (.*);
